// File: hdl/nsdr_pkg.sv
// Shared types and constants for the n-step discounted return collector.
package nsdr_pkg;

    localparam int DATA_W   = 32;
    localparam int WEIGHT_W = 16;

    // unsigned Q1.15 weight of a freshly written slot (1.0)
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 16'd32768;

    // one ring slot as it sits in the slot memory
    typedef struct packed {
        logic        [WEIGHT_W-1:0] weight;
        logic signed [DATA_W-1:0]   sum;
        logic        [DATA_W-1:0]   action;
        logic        [DATA_W-1:0]   state;
    } t_slot;

endpackage

// File: hdl/nsdr_mac.sv
// Slot update datapath: weighted reward accumulate and weight decay, one slot per cycle.
module nsdr_mac #(
    parameter int ADDR_W = 3
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [ADDR_W-1:0]           i_addr,
    input  nsdr_pkg::t_slot             i_slot,
    input  logic signed [31:0]          i_reward,
    input  logic [15:0]                 i_discount,
    output logic                        o_valid,
    output logic [ADDR_W-1:0]           o_addr,
    output nsdr_pkg::t_slot             o_slot
);
    import nsdr_pkg::*;

    logic                     r_valid;
    logic [ADDR_W-1:0]        r_addr;
    t_slot                    r_slot;
    logic signed [48:0]       r_rprod;
    logic [31:0]              r_wprod;

    logic signed [48:0]       l_rp;
    logic signed [33:0]       l_sc;
    logic signed [34:0]       l_acc;
    logic [31:0]              l_wp;
    logic [16:0]              l_nw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_addr  <= i_addr;
        r_slot  <= i_slot;
        r_rprod <= 49'(i_reward) * 49'(signed'({1'b0, i_slot.weight}));
        r_wprod <= 32'(i_slot.weight) * 32'(i_discount);
    end

    // round half up: add 2^14, arithmetic shift by 15 floors
    assign l_rp  = r_rprod + 49'sd16384;
    assign l_sc  = l_rp[48:15];
    assign l_acc = 35'(r_slot.sum) + 35'(l_sc);
    assign l_wp  = r_wprod + 32'd16384;
    assign l_nw  = l_wp[31:15];

    always_comb begin
        o_slot        = r_slot;
        if (l_acc > 35'sd2147483647) begin
            o_slot.sum = 32'sh7fffffff;
        end else if (l_acc < -35'sd2147483648) begin
            o_slot.sum = 32'sh80000000;
        end else begin
            o_slot.sum = l_acc[31:0];
        end
        o_slot.weight = l_nw[16] ? 16'hffff : l_nw[15:0];
    end

    assign o_valid = r_valid;
    assign o_addr  = r_addr;

endmodule

// File: hdl/n_step_discounted_return.sv
// Top level: ring of transitions in a slot memory with sequenced update, emit and flush.
// Sequence: an item is taken in the idle state only; once wrapped, the overwritten slot is
// read and loaded as an output word before the update; after a last item, each flush word
// is read from the slot memory and then loaded. A new item waits until the update and any
// flush are done; the update reads one slot per cycle into the multiply stage.
// Reset: synchronous active low; clears pointer, wrap flag, sequencer, output valid and
// sets the discount to 32440. The slot memory is not cleared; no stale slot contents are used.
module n_step_discounted_return #(
    parameter int RING_DEPTH = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [15:0]  i_cfg_wr_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // state_tag[31:0], action_code[63:32], reward_value[95:64]
    input  logic [95:0]  s_axis_tdata,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // origin_state[31:0], taken_action[63:32], discounted_return[95:64],
    // following_state[127:96]
    output logic [127:0] m_axis_tdata,
    // is_terminal[0]
    output logic         m_axis_tuser,
    output logic         m_axis_tlast
);
    import nsdr_pkg::*;

    localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W = $clog2(RING_DEPTH + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EM_LD = 3'd1;
    localparam logic [2:0] S_UPD   = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_FL_RD = 3'd4;
    localparam logic [2:0] S_FL_LD = 3'd5;

    t_slot r_mem [RING_DEPTH];

    logic [2:0]          r_state, n_state;
    logic [DATA_W-1:0]   r_st, r_ac;
    logic signed [31:0]  r_rew;
    logic                r_end;
    logic [PTR_W-1:0]    r_wp;
    logic                r_wrap;
    logic [CNT_W-1:0]    r_filled;
    logic [CNT_W-1:0]    r_j, n_j;
    logic [15:0]         r_discount;
    t_slot               r_q;
    logic                r_v1;
    logic [PTR_W-1:0]    r_a1;
    logic                r_ovalid;
    logic [127:0]        r_odata;
    logic                r_ouser;
    logic                r_olast;

    logic                w_accept;
    logic                w_rd_en;
    logic [PTR_W-1:0]    w_rd_addr;
    logic                w_ofree;
    logic                w_load;
    logic                w_load_term;
    logic                w_load_last;
    logic                w_j_last;
    t_slot               w_mac_in;
    logic                w_we;
    logic [PTR_W-1:0]    w_wr_addr;
    t_slot               w_wr_slot;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_ofree       = !r_ovalid || m_axis_tready;
    assign w_j_last      = (r_j == r_filled - CNT_W'(1));

    always_comb begin
        n_state     = r_state;
        n_j         = r_j;
        w_rd_en     = 1'b0;
        w_rd_addr   = r_j[PTR_W-1:0];
        w_load      = 1'b0;
        w_load_term = 1'b0;
        w_load_last = 1'b0;
        case (r_state)
            S_IDLE: begin
                n_j = '0;
                if (w_accept) begin
                    if (r_wrap) begin
                        // pull the slot about to be overwritten
                        w_rd_en   = 1'b1;
                        w_rd_addr = r_wp;
                        n_state   = S_EM_LD;
                    end else begin
                        n_state = S_UPD;
                    end
                end
            end
            S_EM_LD: begin
                if (w_ofree) begin
                    w_load      = 1'b1;
                    w_load_last = !r_end;
                    n_state     = S_UPD;
                end
            end
            S_UPD: begin
                w_rd_en = 1'b1;
                n_j     = r_j + CNT_W'(1);
                if (w_j_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_j = '0;
                if (!r_v1 && !w_we) begin
                    n_state = r_end ? S_FL_RD : S_IDLE;
                end
            end
            S_FL_RD: begin
                w_rd_en = 1'b1;
                n_state = S_FL_LD;
            end
            S_FL_LD: begin
                if (w_ofree) begin
                    w_load      = 1'b1;
                    w_load_term = 1'b1;
                    w_load_last = w_j_last;
                    n_j         = r_j + CNT_W'(1);
                    n_state     = w_j_last ? S_IDLE : S_FL_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_j        <= '0;
            r_wp       <= '0;
            r_wrap     <= 1'b0;
            r_discount <= 16'd32440;
            r_v1       <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_j     <= n_j;
            r_v1    <= (r_state == S_UPD);
            if (i_cfg_wr_en) begin
                r_discount <= i_cfg_wr_data;
            end
            if (r_state == S_DRAIN && !r_v1 && !w_we) begin
                if (r_end) begin
                    r_wp   <= '0;
                    r_wrap <= 1'b0;
                end else if (r_wp == PTR_W'(RING_DEPTH - 1)) begin
                    r_wp   <= '0;
                    r_wrap <= 1'b1;
                end else begin
                    r_wp <= r_wp + PTR_W'(1);
                end
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // input word and per-item bookkeeping
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_st     <= s_axis_tdata[31:0];
            r_ac     <= s_axis_tdata[63:32];
            r_rew    <= s_axis_tdata[95:64];
            r_end    <= s_axis_tlast;
            r_filled <= r_wrap ? CNT_W'(RING_DEPTH) : CNT_W'(r_wp) + CNT_W'(1);
        end
        r_a1 <= w_rd_addr;
        if (w_load) begin
            r_odata <= {r_st, r_q.sum, r_q.action, r_q.state};
            r_ouser <= w_load_term;
            r_olast <= w_load_last;
        end
    end

    // slot memory: one read, one write per cycle, registered read data
    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_q <= r_mem[w_rd_addr];
        end
        if (w_we) begin
            r_mem[w_wr_addr] <= w_wr_slot;
        end
    end

    // the current write slot starts fresh instead of its stale contents
    always_comb begin
        w_mac_in = r_q;
        if (r_a1 == r_wp) begin
            w_mac_in.state  = r_st;
            w_mac_in.action = r_ac;
            w_mac_in.sum    = '0;
            w_mac_in.weight = WEIGHT_ONE;
        end
    end

    nsdr_mac #(
        .ADDR_W (PTR_W)
    ) u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_v1),
        .i_addr     (r_a1),
        .i_slot     (w_mac_in),
        .i_reward   (r_rew),
        .i_discount (r_discount),
        .o_valid    (w_we),
        .o_addr     (w_wr_addr),
        .o_slot     (w_wr_slot)
    );

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;
    assign m_axis_tlast  = r_olast;

    a_we_in_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_UPD || r_state == S_DRAIN))
        else $error("slot write outside update");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (!r_ovalid || m_axis_tready))
        else $error("output word overwritten while stalled");

    a_wp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp <= PTR_W'(RING_DEPTH - 1))
        else $error("write pointer beyond ring");

    a_flush_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FL_LD || r_state == S_UPD) |-> (r_j < r_filled))
        else $error("slot index beyond filled count");

    a_drain_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FL_RD) |-> (!r_v1 && !w_we))
        else $error("flush read while update in flight");

endmodule
